[hw/rtl/pnte_pkg.sv]
// Shared types, sizes and command codes for the Petri-net token engine.
// Depends on nothing; every other RTL file refers into it by scoped names.
`default_nettype none

package pnte_pkg;

  localparam int NUM_PLACES      = 16;
  localparam int NUM_TRANSITIONS = 16;
  localparam int TOKEN_BITS      = 8;

  // Fixed field widths of the item ports.
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 4;
  localparam int VALUE_W  = 8;
  localparam int WEIGHT_W = 4;
  localparam int MASK_W   = 16;

  // Storage index widths.
  localparam int TIDX_W = $clog2(NUM_TRANSITIONS);
  localparam int PIDX_W = $clog2(NUM_PLACES);

  // Widths for comparisons and sums that must not wrap.
  localparam int SUM_W     = ((TOKEN_BITS > WEIGHT_W) ? TOKEN_BITS : WEIGHT_W) + 1;
  localparam int VAL_EXT_W = (TOKEN_BITS > VALUE_W) ? TOKEN_BITS : VALUE_W;

  localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_IN    = 3'd0,
    CMD_LOAD_OUT   = 3'd1,
    CMD_SET_MARK   = 3'd2,
    CMD_START      = 3'd3,
    CMD_FINISH     = 3'd4,
    CMD_REV_START  = 3'd5,
    CMD_REV_FINISH = 3'd6,
    CMD_QUERY      = 3'd7
  } cmd_e;

  typedef logic [NUM_PLACES-1:0][TOKEN_BITS-1:0] cnt_vec_t;
  typedef logic [NUM_PLACES-1:0][WEIGHT_W-1:0] wrow_t;
  typedef logic [NUM_TRANSITIONS-1:0][NUM_PLACES-1:0][WEIGHT_W-1:0] wtab_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [IDX_W-1:0]   trans;
    logic [IDX_W-1:0]   place;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic under;
    logic over;
  } flags_t;

endpackage

`default_nettype wire

[hw/rtl/pnte_state.sv]
// Marking and arc-weight storage with the per-command update logic.
// Depends on pnte_pkg for sizes, command codes and the request/flag structs.
`default_nettype none

module pnte_state (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             exec_i,
  input  wire pnte_pkg::req_t   req_i,
  output pnte_pkg::flags_t      flags_o,
  output pnte_pkg::cnt_vec_t    cnt_o,
  output pnte_pkg::wtab_t       in_w_o,
  output pnte_pkg::wtab_t       out_w_o
);

  pnte_pkg::cnt_vec_t cnt_q, cnt_d, cons, prod;
  pnte_pkg::wtab_t    in_w_q, in_w_d, out_w_q, out_w_d;
  pnte_pkg::wrow_t    row;
  logic [pnte_pkg::NUM_PLACES-1:0] under_vec, over_vec;
  logic [pnte_pkg::TIDX_W-1:0]     t_idx;
  logic [pnte_pkg::PIDX_W-1:0]     p_idx;
  logic [pnte_pkg::TOKEN_BITS-1:0] mark_val;
  logic [pnte_pkg::SUM_W-1:0]      need_ext, cnt_ext, sum_ext;
  logic t_ok, p_ok, use_out_row;

  assign t_ok  = 32'(req_i.trans) < 32'(pnte_pkg::NUM_TRANSITIONS);
  assign p_ok  = 32'(req_i.place) < 32'(pnte_pkg::NUM_PLACES);
  assign t_idx = pnte_pkg::TIDX_W'(req_i.trans);
  assign p_idx = pnte_pkg::PIDX_W'(req_i.place);

  // Start takes the input row, finish the output row; the reverse moves swap them.
  assign use_out_row = (req_i.cmd == pnte_pkg::CMD_FINISH) ||
                       (req_i.cmd == pnte_pkg::CMD_REV_START);
  assign row = use_out_row ? out_w_q[t_idx] : in_w_q[t_idx];

  assign mark_val = (pnte_pkg::VAL_EXT_W'(req_i.value) >
                     pnte_pkg::VAL_EXT_W'(pnte_pkg::TOKEN_MAX)) ?
                    pnte_pkg::TOKEN_MAX : pnte_pkg::TOKEN_BITS'(req_i.value);

  // Saturating consume and produce for every place in parallel.
  always_comb begin
    need_ext = '0;
    cnt_ext  = '0;
    sum_ext  = '0;
    for (int p = 0; p < pnte_pkg::NUM_PLACES; p++) begin
      need_ext = pnte_pkg::SUM_W'(row[p]);
      cnt_ext  = pnte_pkg::SUM_W'(cnt_q[p]);
      sum_ext  = cnt_ext + need_ext;
      if (cnt_ext < need_ext) begin
        cons[p]      = '0;
        under_vec[p] = 1'b1;
      end else begin
        cons[p]      = pnte_pkg::TOKEN_BITS'(cnt_ext - need_ext);
        under_vec[p] = 1'b0;
      end
      if (sum_ext > pnte_pkg::SUM_W'(pnte_pkg::TOKEN_MAX)) begin
        prod[p]     = pnte_pkg::TOKEN_MAX;
        over_vec[p] = 1'b1;
      end else begin
        prod[p]     = pnte_pkg::TOKEN_BITS'(sum_ext);
        over_vec[p] = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    in_w_d  = in_w_q;
    out_w_d = out_w_q;
    flags_o = '0;
    if (exec_i) begin
      case (req_i.cmd)
        pnte_pkg::CMD_LOAD_IN: begin
          if (t_ok && p_ok) in_w_d[t_idx][p_idx] = req_i.value[pnte_pkg::WEIGHT_W-1:0];
        end
        pnte_pkg::CMD_LOAD_OUT: begin
          if (t_ok && p_ok) out_w_d[t_idx][p_idx] = req_i.value[pnte_pkg::WEIGHT_W-1:0];
        end
        pnte_pkg::CMD_SET_MARK: begin
          if (p_ok) cnt_d[p_idx] = mark_val;
        end
        pnte_pkg::CMD_START, pnte_pkg::CMD_REV_START: begin
          if (t_ok) begin
            cnt_d         = cons;
            flags_o.under = |under_vec;
          end
        end
        pnte_pkg::CMD_FINISH, pnte_pkg::CMD_REV_FINISH: begin
          if (t_ok) begin
            cnt_d        = prod;
            flags_o.over = |over_vec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      in_w_q  <= '0;
      out_w_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      in_w_q  <= in_w_d;
      out_w_q <= out_w_d;
    end
  end

  assign cnt_o   = cnt_q;
  assign in_w_o  = in_w_q;
  assign out_w_o = out_w_q;

endmodule

`default_nettype wire

[hw/rtl/pnte_cover.sv]
// Coverage check of one arc-weight table against the marking, giving a mask.
// Depends on pnte_pkg for the table and marking types.
`default_nettype none

module pnte_cover (
  input  wire pnte_pkg::cnt_vec_t        cnt_i,
  input  wire pnte_pkg::wtab_t           wtab_i,
  output logic [pnte_pkg::MASK_W-1:0]    mask_o
);

  for (genvar k = 0; k < pnte_pkg::MASK_W; k++) begin : g_bit
    if (k < pnte_pkg::NUM_TRANSITIONS) begin : g_used
      always_comb begin
        mask_o[k] = 1'b1;
        for (int p = 0; p < pnte_pkg::NUM_PLACES; p++) begin
          if (pnte_pkg::SUM_W'(cnt_i[p]) < pnte_pkg::SUM_W'(wtab_i[k][p])) begin
            mask_o[k] = 1'b0;
          end
        end
      end
    end else begin : g_unused
      assign mask_o[k] = 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/petri_net_token_engine_core.sv]
// Top level of the Petri-net token engine: handshakes, flag stage, result register.
// Depends on pnte_pkg, pnte_state and pnte_cover.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   command_i, transition_index_i,
//                                                  place_index_i, value_i
//   out       output     out_valid_o / out_ready_i enabled_mask_o,
//                                                  reverse_enabled_mask_o,
//                                                  underflow_o, overflow_o
//
// Every beat takes one cycle of throughput while the output is not stalled. On the
// accepting edge the command updates the marking and weight registers and its
// flags enter the middle stage; both enable masks are then computed from the
// updated marking, and the whole result is loaded into the output register
// when the middle stage advances to it.
// Reset clears the marking, both weight tables and all valid bits at once.
// While the output register holds an untaken result and the middle stage is
// full, in_ready_o is low and the marking stays frozen, so the masks computed
// for the waiting middle beat remain correct.
`default_nettype none

module petri_net_token_engine_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pnte_pkg::CMD_W-1:0]    command_i,
  input  wire logic [pnte_pkg::IDX_W-1:0]    transition_index_i,
  input  wire logic [pnte_pkg::IDX_W-1:0]    place_index_i,
  input  wire logic [pnte_pkg::VALUE_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [pnte_pkg::MASK_W-1:0]        enabled_mask_o,
  output logic [pnte_pkg::MASK_W-1:0]        reverse_enabled_mask_o,
  output logic                               underflow_o,
  output logic                               overflow_o
);

  pnte_pkg::req_t     req;
  pnte_pkg::flags_t   flags_now, flags_q;
  pnte_pkg::cnt_vec_t cnt;
  pnte_pkg::wtab_t    in_w, out_w;
  logic [pnte_pkg::MASK_W-1:0] fwd_mask, rev_mask;
  logic [pnte_pkg::MASK_W-1:0] fwd_mask_q, rev_mask_q;
  logic out_under_q, out_over_q;
  logic mid_valid_q, mid_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_fire, out_adv;

  // The output register can load when it is empty or its beat is being taken.
  assign out_adv    = !out_valid_q || out_ready_i;
  // The middle stage can take a beat when it is empty or moves on this cycle.
  assign in_ready_o = !mid_valid_q || out_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign req.cmd   = pnte_pkg::cmd_e'(command_i);
  assign req.trans = transition_index_i;
  assign req.place = place_index_i;
  assign req.value = value_i;

  // Command execution: marking and weight tables update on the accepting edge.
  pnte_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .exec_i  (in_fire),
    .req_i   (req),
    .flags_o (flags_now),
    .cnt_o   (cnt),
    .in_w_o  (in_w),
    .out_w_o (out_w)
  );

  // Forward enabling checks input arcs, reverse enabling checks output arcs.
  pnte_cover u_cover_fwd (
    .cnt_i  (cnt),
    .wtab_i (in_w),
    .mask_o (fwd_mask)
  );

  pnte_cover u_cover_rev (
    .cnt_i  (cnt),
    .wtab_i (out_w),
    .mask_o (rev_mask)
  );

  always_comb begin
    mid_valid_d = mid_valid_q;
    if (in_fire) begin
      mid_valid_d = 1'b1;
    end else if (out_adv) begin
      mid_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = mid_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= mid_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Flags of the beat that just executed wait here while its masks are formed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      flags_q <= flags_now;
    end
  end

  // The marking seen here belongs to the middle beat, since nothing newer has
  // executed yet when that beat moves to the output.
  always_ff @(posedge clk_i) begin
    if (out_adv && mid_valid_q) begin
      fwd_mask_q  <= fwd_mask;
      rev_mask_q  <= rev_mask;
      out_under_q <= flags_q.under;
      out_over_q  <= flags_q.over;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign enabled_mask_o         = fwd_mask_q;
  assign reverse_enabled_mask_o = rev_mask_q;
  assign underflow_o            = out_under_q;
  assign overflow_o             = out_over_q;

  // A command either consumes or produces, never both.
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_under_q && out_over_q))
    else $error("underflow and overflow raised for the same beat");

  // The marking changes only on an accepting edge.
  a_marking_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(cnt))
    else $error("marking changed without an accepted beat");

  // An accepted beat always lands in the middle stage.
  a_mid_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> mid_valid_q)
    else $error("accepted beat lost before the middle stage");

  // A full middle stage moves to the output register whenever it can advance.
  a_mid_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid_q && out_adv |=> out_valid_q)
    else $error("middle beat did not reach the output register");

endmodule

`default_nettype wire
